### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_SIZE       = 3'd6
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_r;    // push front: each cell takes its left neighbor, cell 0 the pushed word
    logic shift_l;    // pop front: every cell takes its right neighbor
    logic load_tail;  // push back: first empty cell loads the word
    logic drop_tail;  // pop back: last occupied cell empties
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: a word and an occupied flag, loaded
// from either neighbor or from the pushed word.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire deq_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [deq_pkg::DataW-1:0]  push_data_i,
  input  wire logic [deq_pkg::DataW-1:0]  left_data_i,
  input  wire logic                       left_valid_i,
  input  wire logic [deq_pkg::DataW-1:0]  right_data_i,
  input  wire logic                       right_valid_i,
  output logic [deq_pkg::DataW-1:0]       data_o,
  output logic                            valid_o,
  output logic                            last_o
);

  logic [deq_pkg::DataW-1:0] data_q;
  logic                      valid_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.shift_r) begin
      data_q <= left_data_i;
    end else if (ctrl_i.shift_l) begin
      data_q <= right_data_i;
    end else if (ctrl_i.load_tail && left_valid_i && !valid_q) begin
      data_q <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      priority if (ctrl_i.shift_r) begin
        valid_q <= left_valid_i;
      end else if (ctrl_i.shift_l) begin
        valid_q <= right_valid_i;
      end else if (ctrl_i.load_tail && left_valid_i && !valid_q) begin
        valid_q <= 1'b1;
      end else if (ctrl_i.drop_tail && valid_q && !right_valid_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign last_o  = valid_q && !right_valid_i;

endmodule

`default_nettype wire

### rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of signed 32-bit words held in a row of DEPTH cells, front
// at cell 0. Push/pop at the front shift the whole row; push/pop at the back
// touch only the boundary cell.
//
//   channel   | handshake              | fields
//   ----------+------------------------+-------------------------------
//   request   | start_i, busy_o        | mode_i, value_i
//   result    | done_o (one cycle)     | status_o, data_o, fill_o
//
// One transaction per cycle: the result appears the cycle after start_i.
// The rate is set by the registered cell update plus the back-word select.
// busy_o stays low; any cycle can take a new transaction.
// Reset empties the row at once (occupied flags clear); no sweep.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       start_i,
  output logic                                      busy_o,
  input  wire logic [deq_pkg::ModeW-1:0]            mode_i,
  input  wire logic signed [deq_pkg::DataW-1:0]     value_i,
  output logic                                      done_o,
  output logic [deq_pkg::StatusW-1:0]               status_o,
  output logic signed [deq_pkg::DataW-1:0]          data_o,
  output logic [$clog2(DEPTH+1)-1:0]                fill_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                      accept;
  logic                      full;
  logic                      empty;
  deq_pkg::cell_ctrl_t       ctrl;
  deq_pkg::status_e          status_d;
  logic [deq_pkg::DataW-1:0] rdata_d;
  logic [deq_pkg::DataW-1:0] back_data;
  logic [CntW-1:0]           count_q, count_d;

  logic [deq_pkg::DataW-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          cell_last;

  logic                      done_q;
  deq_pkg::status_e          status_q;
  logic [deq_pkg::DataW-1:0] data_q;
  logic [CntW-1:0]           fill_q;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [deq_pkg::DataW-1:0] l_data, r_data;
    logic                      l_valid, r_valid;

    if (g == 0) begin : g_head
      assign l_data  = value_i;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .push_data_i   (value_i),
      .left_data_i   (l_data),
      .left_valid_i  (l_valid),
      .right_data_i  (r_data),
      .right_valid_i (r_valid),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g]),
      .last_o        (cell_last[g])
    );
  end

  // one-hot select of the back word
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | (cell_data[i] & {deq_pkg::DataW{cell_last[i]}});
    end
  end

  always_comb begin
    ctrl     = '0;
    status_d = deq_pkg::STATUS_OK;
    rdata_d  = '0;
    count_d  = count_q;
    unique case (deq_pkg::mode_e'(mode_i))
      deq_pkg::MODE_PUSH_FRONT,
      deq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          status_d = deq_pkg::STATUS_FULL;
        end else begin
          ctrl.shift_r   = accept && (mode_i == deq_pkg::MODE_PUSH_FRONT);
          ctrl.load_tail = accept && (mode_i == deq_pkg::MODE_PUSH_BACK);
          count_d        = count_q + 1'b1;
        end
      end
      deq_pkg::MODE_POP_FRONT,
      deq_pkg::MODE_PEEK_FRONT: begin
        if (empty) begin
          status_d = deq_pkg::STATUS_EMPTY;
        end else begin
          rdata_d = cell_data[0];
          if (mode_i == deq_pkg::MODE_POP_FRONT) begin
            ctrl.shift_l = accept;
            count_d      = count_q - 1'b1;
          end
        end
      end
      deq_pkg::MODE_POP_BACK,
      deq_pkg::MODE_PEEK_BACK: begin
        if (empty) begin
          status_d = deq_pkg::STATUS_EMPTY;
        end else begin
          rdata_d = back_data;
          if (mode_i == deq_pkg::MODE_POP_BACK) begin
            ctrl.drop_tail = accept;
            count_d        = count_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= rdata_d;
      fill_q   <= count_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign data_o   = data_q;
  assign fill_o   = fill_q;

`ifndef SYNTH
  a_fill_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("occupied cells disagree with fill count");

  a_single_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_last) && ((cell_last == '0) == empty))
    else $error("back of queue not unique");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o && (fill_o == count_q))
    else $error("result missing or fill wrong");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o && $stable(count_q))
    else $error("result or state change without a transaction");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (mode_i == deq_pkg::MODE_PUSH_FRONT ||
                       mode_i == deq_pkg::MODE_PUSH_BACK)
    |=> status_o == deq_pkg::STATUS_FULL && $stable(count_q))
    else $error("push into full queue not rejected");
`endif

endmodule

`default_nettype wire
